FILE: rtl/mruss_pkg.sv
// Shared constants, types and helper functions for the multi-row
// unbiased space-saving sketch. No dependencies.
`timescale 1ns / 1ps

package mruss_pkg;

	// Sketch geometry.
	localparam int ROWS      = 2;
	localparam int BUCKETS   = 1024;
	localparam int KEY_BYTES = 8;

	// Field widths fixed by the interface.
	localparam int KEY_W = 64;
	localparam int IDX_W = 10;
	localparam int RND_W = 16;
	localparam int CNT_W = 32;
	localparam int ACT_W = 2;

	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;

	// Only the low KEY_BYTES bytes of a key are stored and compared.
	localparam logic [KEY_W-1:0] KEY_MASK  = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);
	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [RND_W-1:0] RND_LIMIT = {RND_W{1'b1}};

	// Result actions.
	localparam logic [ACT_W-1:0] ACT_MATCH   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLAIM   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REPLACE = 2'd2;
	localparam logic [ACT_W-1:0] ACT_KEEP    = 2'd3;

	typedef logic [BUCKET_W-1:0] addr_t;

	// One bucket as stored in a row memory.
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} bucket_t;

	// Per-row findings registered between evaluation and write-back.
	typedef struct packed {
		logic             hit;
		logic             empty;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] count_inc;
		logic             repl;
	} row_eval_t;

	// Saturating increment of a bucket count.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
	endfunction

endpackage

FILE: rtl/mruss_item_if.sv
// Input channel of the sketch: one word per flow update.
// Depends on mruss_pkg for field widths.
`timescale 1ns / 1ps

interface mruss_item_if;
	logic                       valid;
	logic                       ready;
	logic [mruss_pkg::KEY_W-1:0] flow_key;
	logic [mruss_pkg::IDX_W-1:0] bucket_row0;
	logic [mruss_pkg::IDX_W-1:0] bucket_row1;
	logic [mruss_pkg::RND_W-1:0] random_value;

	modport source (output valid, flow_key, bucket_row0, bucket_row1, random_value,
		input ready);
	modport sink (input valid, flow_key, bucket_row0, bucket_row1, random_value,
		output ready);
endinterface

FILE: rtl/mruss_result_if.sv
// Output channel of the sketch: one result word per input word.
// Depends on mruss_pkg for field widths.
`timescale 1ns / 1ps

interface mruss_result_if;
	logic                       valid;
	logic                       ready;
	logic [mruss_pkg::ACT_W-1:0] action;
	logic                       row_used;
	logic [mruss_pkg::CNT_W-1:0] new_count;

	modport source (output valid, action, row_used, new_count, input ready);
	modport sink (input valid, action, row_used, new_count, output ready);
endinterface

FILE: rtl/mruss_bank.sv
// One row of buckets: a single-port-write, single-port-read synchronous RAM
// with registered read data. Depends on mruss_pkg.
`timescale 1ns / 1ps

module mruss_bank (
	input  logic              clk,
	input  logic              rd_en,
	input  mruss_pkg::addr_t  rd_addr,
	output mruss_pkg::bucket_t rd_data,
	input  logic              wr_en,
	input  mruss_pkg::addr_t  wr_addr,
	input  mruss_pkg::bucket_t wr_data
);
	import mruss_pkg::*;

	bucket_t mem [BUCKETS];

	// Read data holds until the next read, so the write-back stage can use it.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

FILE: rtl/multirow_unbiased_space_saving.sv
// Top level of the multi-row unbiased space-saving sketch.
// Depends on mruss_pkg, mruss_item_if, mruss_result_if and mruss_bank.
//
// Usage:
// Words arrive on the item channel (flow key, one bucket index per row and
// a random value) and each produces exactly one word on the result channel
// (action, row updated, count after the update). Both channels use a
// valid/ready handshake; a word moves when valid and ready are high at a
// rising clock edge.
// Each row is a synchronous RAM of BUCKETS entries holding valid, key and
// count. An accepted word reads all rows at its accept edge, is evaluated
// in the next cycle and is written back in the write-back step, when the
// result register loads. A new word is taken only after the last one is
// written back, since its read-evaluate-write loop runs through the row RAMs.
// Only one word is in flight, so read and write never touch the same entry
// in the same cycle.
// After reset a clearing pass over all BUCKETS entries zeroes the valid
// bits of every row; ready stays low until it is done.
// The result register holds one finished word. While it waits for the
// receiver the next word is still accepted and evaluated; it waits in the
// write-back step until the result register frees up.
`timescale 1ns / 1ps

module multirow_unbiased_space_saving (
	input logic            clk,
	input logic            arst_n,
	mruss_item_if.sink     item,
	mruss_result_if.source result
);
	import mruss_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EVAL  = 2'd2;
	localparam logic [1:0] ST_WRITE = 2'd3;

	logic [1:0]       state_q;
	addr_t            clr_q;

	logic [KEY_W-1:0] key_q;
	addr_t            idx_q [ROWS];
	logic [RND_W-1:0] rnd_q;

	row_eval_t        ev_d [ROWS];
	row_eval_t        ev_q [ROWS];

	addr_t            in_idx  [ROWS];
	bucket_t          rd_data [ROWS];
	logic [ROWS-1:0]  wr_en;
	addr_t            wr_addr [ROWS];
	bucket_t          wr_data [ROWS];

	logic             acc;
	logic             wr_fire;
	logic [ROW_W-1:0] sel;
	logic [ACT_W-1:0] act;
	logic [CNT_W-1:0] cnt_new;
	logic [CNT_W-1:0] min_cnt;
	logic [KEY_W-1:0] key_new;
	logic             found;

	logic             out_valid_q;
	logic [ACT_W-1:0] out_act_q;
	logic             out_row_q;
	logic [CNT_W-1:0] out_cnt_q;

	// Handshake on the input side.
	assign item.ready = (state_q == ST_IDLE);
	assign acc        = item.valid && item.ready;

	// Row zero uses its own index; every later row uses the second one.
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			in_idx[r] = (r == 0) ? addr_t'(item.bucket_row0) : addr_t'(item.bucket_row1);
		end
	end

	// Row memories.
	for (genvar g = 0; g < ROWS; g++) begin : g_row
		mruss_bank u_bank (
			.clk     (clk),
			.rd_en   (acc),
			.rd_addr (in_idx[g]),
			.rd_data (rd_data[g]),
			.wr_en   (wr_en[g]),
			.wr_addr (wr_addr[g]),
			.wr_data (wr_data[g])
		);
	end

	// Capture the accepted word.
	always_ff @(posedge clk) begin
		if (acc) begin
			key_q <= item.flow_key & KEY_MASK;
			rnd_q <= item.random_value;
			for (int r = 0; r < ROWS; r++) begin
				idx_q[r] <= in_idx[r];
			end
		end
	end

	// Evaluate each row against the key and prepare the replacement test.
	// For a nonzero rnd the test rnd * (count + 1) < 65535 can only pass for a
	// small count, so a 16 by 16 bit product is enough; rnd zero always passes.
	always_comb begin
		logic [2*RND_W-1:0] prod;
		logic               cnt_low;
		for (int r = 0; r < ROWS; r++) begin
			cnt_low = rd_data[r].count < CNT_W'(RND_LIMIT - RND_W'(1));
			prod  = {{RND_W{1'b0}}, rnd_q} *
				{{RND_W{1'b0}}, rd_data[r].count[RND_W-1:0] + RND_W'(1)};
			ev_d[r].hit       = rd_data[r].valid && (rd_data[r].key == key_q);
			ev_d[r].empty     = !rd_data[r].valid;
			ev_d[r].count     = rd_data[r].count;
			ev_d[r].count_inc = sat_inc(rd_data[r].count);
			ev_d[r].repl      = (rnd_q == '0) ||
				(cnt_low && (prod < {{RND_W{1'b0}}, RND_LIMIT}));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			for (int r = 0; r < ROWS; r++) begin
				ev_q[r] <= ev_d[r];
			end
		end
	end

	// Pick the row to update: first match, else first empty bucket,
	// else the smallest count with the lowest row winning ties.
	always_comb begin
		found   = 1'b0;
		sel     = '0;
		act     = ACT_MATCH;
		cnt_new = ev_q[0].count_inc;
		min_cnt = ev_q[0].count;
		for (int r = 0; r < ROWS; r++) begin
			if (!found && ev_q[r].hit) begin
				found   = 1'b1;
				sel     = ROW_W'(r);
				act     = ACT_MATCH;
				cnt_new = ev_q[r].count_inc;
			end
		end
		for (int r = 0; r < ROWS; r++) begin
			if (!found && ev_q[r].empty) begin
				found   = 1'b1;
				sel     = ROW_W'(r);
				act     = ACT_CLAIM;
				cnt_new = CNT_W'(1);
			end
		end
		if (!found) begin
			for (int r = 1; r < ROWS; r++) begin
				if (ev_q[r].count < min_cnt) begin
					min_cnt = ev_q[r].count;
					sel     = ROW_W'(r);
				end
			end
			act     = ev_q[sel].repl ? ACT_REPLACE : ACT_KEEP;
			cnt_new = ev_q[sel].count_inc;
		end
		key_new = (act == ACT_KEEP) ? rd_data[sel].key : key_q;
	end

	assign wr_fire = (state_q == ST_WRITE) && (!out_valid_q || result.ready);

	// Memory writes: the clearing pass hits every row, write-back only one.
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			if (state_q == ST_CLEAR) begin
				wr_en[r]   = 1'b1;
				wr_addr[r] = clr_q;
				wr_data[r] = '0;
			end else begin
				wr_en[r]   = wr_fire && (sel == ROW_W'(r));
				wr_addr[r] = idx_q[r];
				wr_data[r] = '{valid: 1'b1, key: key_new, count: cnt_new};
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + addr_t'(1);
					if (clr_q == addr_t'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (wr_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			out_act_q <= act;
			out_row_q <= sel[0];
			out_cnt_q <= cnt_new;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.action    = out_act_q;
	assign result.row_used  = out_row_q;
	assign result.new_count = out_cnt_q;

	// No word is taken while the valid bits are being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !item.ready)
		else $error("item accepted during clearing pass");

	// Write-back touches exactly one row.
	a_one_row_written: assert property (@(posedge clk) disable iff (!arst_n)
		wr_fire |-> $onehot(wr_en))
		else $error("write-back did not select exactly one row");

	// A claimed bucket always starts at one.
	a_claim_count_one: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.action == ACT_CLAIM)) |-> (result.new_count == CNT_W'(1)))
		else $error("claimed bucket count is not one");

	// An accepted word passes through evaluation and reaches write-back.
	a_accept_to_write: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> ##1 (state_q == ST_WRITE))
		else $error("accepted word did not reach write-back");

endmodule
